### hw/rtl/kcl_pkg.sv
package kcl_pkg;

  // Input item: key press or time tick
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] key_code;
  } in_item_t;

  // Result events
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_STORED   = 3'd1;
  localparam logic [2:0] EV_WRONG    = 3'd2;
  localparam logic [2:0] EV_LOCKED   = 3'd3;
  localparam logic [2:0] EV_OPENED   = 3'd4;
  localparam logic [2:0] EV_CLOSED   = 3'd5;
  localparam logic [2:0] EV_UNLOCKED = 3'd6;

  typedef struct packed {
    logic [2:0] event_res;
    logic [3:0] tries_left;
    logic       door_open;
    logic       lock_indicator;
    logic [4:0] digits_entered;
  } out_item_t;

  // Configuration register map
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_TRY_LIMIT     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LOCKOUT_TICKS = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_OPEN_TICKS    = 2'd2;

  localparam logic [3:0]  RST_TRY_LIMIT     = 4'd3;
  localparam logic [15:0] RST_LOCKOUT_TICKS = 16'd15000;
  localparam logic [15:0] RST_OPEN_TICKS    = 16'd30000;

  // Operating modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_OPEN = 2'd1;
  localparam logic [1:0] MODE_LOCK = 2'd2;

endpackage

### hw/rtl/keypad_code_lock_top.sv
// Keypad combination lock with retry lockout.
//
// Input channel (in_valid / in_stall / in_data): one transfer per debounced key
// press (op = key) or per time tick (op = tick). Every input transfer yields
// exactly one result transfer on the output channel (out_valid / out_stall /
// out_data) carrying the event, remaining tries, door and lock outputs and the
// number of keys collected in the current entry.
// Configuration channel (cfg_valid / cfg_ready / cfg_addr / cfg_wdata): writes
// the try limit, lockout_ticks and open_ticks; cfg_ready is always high. Write
// only while no item is in flight; a new try limit is used at the next refill.
// Pipeline: each item passes the input register, then the result register.
// Throughput: one item per cycle while out_stall does not hold a waiting result,
// set by the single compare-and-update step between the two registers.
// Stall: when out_stall holds a waiting result, the input register still takes
// one more item; after that in_stall rises until the result is taken.
// Reset: the lock forgets its code, tries refill to the try limit, the door is
// closed, no lockout runs and the config registers return to their defaults.
module keypad_code_lock_top #(
  parameter int unsigned CODE_LENGTH = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  kcl_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output kcl_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kcl_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [kcl_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int unsigned IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CODE_LENGTH - 1);

  // Config registers
  logic [3:0]  try_limit_r;
  logic [15:0] lockout_ticks_r;
  logic [15:0] open_ticks_r;

  // Pipeline registers
  logic               s1_valid_r;
  kcl_pkg::in_item_t  s1_data_r;
  logic               out_valid_r;
  kcl_pkg::out_item_t out_data_r;

  // Lock state
  logic [7:0]       stored_code_r [CODE_LENGTH];
  logic [7:0]       entered_code_r[CODE_LENGTH];
  logic             code_set_r, code_set_nxt;
  logic [IDX_W-1:0] digit_cnt_r, digit_cnt_nxt;
  logic [3:0]       tries_r, tries_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic [15:0]      countdown_r, countdown_nxt;

  logic       advance;
  logic       s1_fire;
  logic       store_we;
  logic       entry_we;
  logic       code_match;
  logic [2:0] event_nxt;

  // Result register frees up when empty or being taken this cycle
  assign advance   = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && advance;
  assign in_stall  = s1_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      try_limit_r     <= kcl_pkg::RST_TRY_LIMIT;
      lockout_ticks_r <= kcl_pkg::RST_LOCKOUT_TICKS;
      open_ticks_r    <= kcl_pkg::RST_OPEN_TICKS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        kcl_pkg::CFG_TRY_LIMIT:     try_limit_r     <= cfg_wdata[3:0];
        kcl_pkg::CFG_LOCKOUT_TICKS: lockout_ticks_r <= cfg_wdata;
        kcl_pkg::CFG_OPEN_TICKS:    open_ticks_r    <= cfg_wdata;
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  // Input register: hold while the result side is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  // Compare the collected keys plus the current one against the stored code
  always_comb begin
    code_match = (s1_data_r.key_code == stored_code_r[CODE_LENGTH-1]);
    for (int i = 0; i < int'(CODE_LENGTH) - 1; i++) begin
      if (entered_code_r[i] != stored_code_r[i]) begin
        code_match = 1'b0;
      end
    end
  end

  // Next state for the item leaving the input register
  always_comb begin
    code_set_nxt  = code_set_r;
    digit_cnt_nxt = digit_cnt_r;
    tries_nxt     = tries_r;
    mode_nxt      = mode_r;
    countdown_nxt = countdown_r;
    event_nxt     = kcl_pkg::EV_NONE;
    store_we      = 1'b0;
    entry_we      = 1'b0;

    if (s1_data_r.op == kcl_pkg::OP_TICK) begin
      if (mode_r != kcl_pkg::MODE_IDLE) begin
        if (countdown_r <= 16'd1) begin
          countdown_nxt = '0;
          mode_nxt      = kcl_pkg::MODE_IDLE;
          if (mode_r == kcl_pkg::MODE_LOCK) begin
            tries_nxt = try_limit_r;
            event_nxt = kcl_pkg::EV_UNLOCKED;
          end else begin
            event_nxt = kcl_pkg::EV_CLOSED;
          end
        end else begin
          countdown_nxt = countdown_r - 16'd1;
        end
      end
    end else if (mode_r == kcl_pkg::MODE_IDLE) begin
      // Keys during open or lockout periods fall through untouched
      if (!code_set_r) begin
        store_we = 1'b1;
        if (digit_cnt_r == LAST_IDX) begin
          digit_cnt_nxt = '0;
          code_set_nxt  = 1'b1;
          event_nxt     = kcl_pkg::EV_STORED;
        end else begin
          digit_cnt_nxt = digit_cnt_r + 1'b1;
        end
      end else begin
        entry_we = 1'b1;
        if (digit_cnt_r == LAST_IDX) begin
          digit_cnt_nxt = '0;
          if (code_match) begin
            mode_nxt      = kcl_pkg::MODE_OPEN;
            countdown_nxt = open_ticks_r;
            tries_nxt     = try_limit_r;
            event_nxt     = kcl_pkg::EV_OPENED;
          end else if (tries_r > 4'd1) begin
            tries_nxt = tries_r - 4'd1;
            event_nxt = kcl_pkg::EV_WRONG;
          end else begin
            // Last try failed: hold tries until the lockout ends
            mode_nxt      = kcl_pkg::MODE_LOCK;
            countdown_nxt = lockout_ticks_r;
            event_nxt     = kcl_pkg::EV_LOCKED;
          end
        end else begin
          digit_cnt_nxt = digit_cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_set_r  <= 1'b0;
      digit_cnt_r <= '0;
      tries_r     <= kcl_pkg::RST_TRY_LIMIT;
      mode_r      <= kcl_pkg::MODE_IDLE;
      countdown_r <= '0;
    end else if (s1_fire) begin
      code_set_r  <= code_set_nxt;
      digit_cnt_r <= digit_cnt_nxt;
      tries_r     <= tries_nxt;
      mode_r      <= mode_nxt;
      countdown_r <= countdown_nxt;
    end
  end

  // Code stores: written before read, no reset
  always_ff @(posedge clk) begin
    if (s1_fire && store_we) begin
      stored_code_r[digit_cnt_r] <= s1_data_r.key_code;
    end
    if (s1_fire && entry_we) begin
      entered_code_r[digit_cnt_r] <= s1_data_r.key_code;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r.event_res      <= event_nxt;
      out_data_r.tries_left     <= tries_nxt;
      out_data_r.door_open      <= (mode_nxt == kcl_pkg::MODE_OPEN);
      out_data_r.lock_indicator <= (mode_nxt == kcl_pkg::MODE_LOCK);
      out_data_r.digits_entered <= 5'(digit_cnt_nxt);
    end
  end

  // Door open and lockout never show together
  a_door_lock_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.door_open && out_data_r.lock_indicator))
    else $error("door open and lock indicator both set");

  // Partial entries are discarded whenever the lock leaves idle
  a_cnt_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != kcl_pkg::MODE_IDLE) |-> (digit_cnt_r == '0))
    else $error("digit count nonzero outside idle mode");

  // An open event always reports the door open
  a_open_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.event_res == kcl_pkg::EV_OPENED) |-> out_data_r.door_open)
    else $error("open event without door open");

  // Input side only stalls with an item held in the input register
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with empty pipeline");

  // A stalled input item stays in place
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_stall) |-> (s1_valid_r && $stable(s1_data_r)))
    else $error("input register changed under stall");

endmodule
